### hw/rtl/rfqg_pkg.sv
`timescale 1ns / 1ps

package rfqg_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 48;

  localparam logic [CFG_INDEX_W-1:0] CFG_ACCEPT_FLOAT_MODE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_SAT_COUNT     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DILUTION      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_CORR_AGE      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ODOM_GAP      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_JUMP3D_LIMIT_SQ   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_JUMP2D_LIMIT_SQ   = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHI2_LIMIT        = 3'd7;

  localparam logic KIND_FIX  = 1'b0;
  localparam logic KIND_CHI2 = 1'b1;

  localparam logic [1:0] SOL_FLOAT = 2'd1;
  localparam logic [1:0] SOL_FIXED = 2'd2;

  localparam logic        RST_ACCEPT_FLOAT_MODE = 1'b0;
  localparam logic [5:0]  RST_MIN_SAT_COUNT     = 6'd6;
  localparam logic [13:0] RST_MAX_DILUTION      = 14'd200;
  localparam logic [15:0] RST_MAX_CORR_AGE      = 16'd5000;
  localparam logic [14:0] RST_MAX_ODOM_GAP      = 15'd500;
  localparam logic [47:0] RST_JUMP3D_LIMIT_SQ   = 48'd4000000;
  localparam logic [47:0] RST_JUMP2D_LIMIT_SQ   = 48'd2250000;
  localparam logic [31:0] RST_CHI2_LIMIT        = 32'd1048576;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  typedef struct packed {
    logic               kind;
    logic [1:0]         sol_mode;
    logic [5:0]         sat_count;
    logic [13:0]        dilution;
    logic [15:0]        corr_age;
    logic signed [23:0] east_offset;
    logic signed [23:0] north_offset;
    logic signed [23:0] up_offset;
    logic signed [15:0] time_gap;
    logic               odom_valid;
    logic [31:0]        chi2_value;
  } in_word_t;

  typedef struct packed {
    logic accepted;
    logic quality_ok;
    logic jump_ok;
    logic blackout;
    logic inlier;
  } out_word_t;

  typedef struct packed {
    logic        accept_float_mode;
    logic [5:0]  min_sat_count;
    logic [13:0] max_dilution;
    logic [15:0] max_corr_age;
    logic [14:0] max_odom_gap;
    logic [47:0] jump3d_limit_sq;
    logic [47:0] jump2d_limit_sq;
    logic [31:0] chi2_limit;
  } cfg_t;

  typedef struct packed {
    logic kind;
    logic quality_ok;
    logic jump_ok;
    logic inlier;
  } entry_t;

endpackage

### hw/rtl/rfqg_ifs.sv
`timescale 1ns / 1ps

interface rfqg_in_if;
  logic               valid;
  logic               ready;
  rfqg_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rfqg_out_if;
  logic                valid;
  logic                ready;
  rfqg_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/rfqg_front.sv
`timescale 1ns / 1ps

module rfqg_front (
  input  logic               clk,
  input  logic               rst_n,
  input  rfqg_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  rfqg_pkg::in_word_t in_word,
  output logic               ent_valid,
  input  logic               ent_ready,
  output rfqg_pkg::entry_t   ent
);

  typedef struct packed {
    logic        kind;
    logic        quality_ok;
    logic        bypass;
    logic        inlier;
    logic [46:0] ee;
    logic [46:0] nn;
    logic [46:0] uu;
  } s1_t;

  typedef struct packed {
    logic        kind;
    logic        quality_ok;
    logic        bypass;
    logic        inlier;
    logic [47:0] sq2;
    logic [46:0] uu;
  } s2_t;

  logic               adv;
  logic               s1_v_r;
  logic               s2_v_r;
  s1_t                s1_r;
  s1_t                s1_nxt;
  s2_t                s2_r;
  s2_t                s2_nxt;
  logic               type_ok;
  logic [16:0]        gap_abs;
  logic signed [47:0] ee_full;
  logic signed [47:0] nn_full;
  logic signed [47:0] uu_full;
  logic [48:0]        sq3;

  assign adv      = !s2_v_r || ent_ready;
  assign in_ready = adv;

  assign type_ok = (in_word.sol_mode == rfqg_pkg::SOL_FIXED) ||
                   (cfg.accept_float_mode && in_word.sol_mode == rfqg_pkg::SOL_FLOAT);
  assign gap_abs = in_word.time_gap[15] ? (17'd0 - {1'b1, in_word.time_gap})
                                        : {1'b0, in_word.time_gap};
  assign ee_full = 48'(in_word.east_offset) * 48'(in_word.east_offset);
  assign nn_full = 48'(in_word.north_offset) * 48'(in_word.north_offset);
  assign uu_full = 48'(in_word.up_offset) * 48'(in_word.up_offset);

  always_comb begin
    s1_nxt.kind       = in_word.kind;
    s1_nxt.quality_ok = type_ok &&
                        (in_word.sat_count >= cfg.min_sat_count) &&
                        (in_word.dilution <= cfg.max_dilution) &&
                        (in_word.corr_age <= cfg.max_corr_age);
    s1_nxt.bypass     = !in_word.odom_valid || (gap_abs > {2'b00, cfg.max_odom_gap});
    s1_nxt.inlier     = in_word.chi2_value <= cfg.chi2_limit;
    s1_nxt.ee         = ee_full[46:0];
    s1_nxt.nn         = nn_full[46:0];
    s1_nxt.uu         = uu_full[46:0];
  end

  always_comb begin
    s2_nxt.kind       = s1_r.kind;
    s2_nxt.quality_ok = s1_r.quality_ok;
    s2_nxt.bypass     = s1_r.bypass;
    s2_nxt.inlier     = s1_r.inlier;
    s2_nxt.sq2        = {1'b0, s1_r.ee} + {1'b0, s1_r.nn};
    s2_nxt.uu         = s1_r.uu;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
    end
  end

  assign sq3 = {1'b0, s2_r.sq2} + {2'b00, s2_r.uu};

  assign ent_valid      = s2_v_r;
  assign ent.kind       = s2_r.kind;
  assign ent.quality_ok = s2_r.quality_ok;
  assign ent.jump_ok    = s2_r.quality_ok &&
                          (s2_r.bypass ||
                           ((sq3 <= {1'b0, cfg.jump3d_limit_sq}) &&
                            (s2_r.sq2 <= cfg.jump2d_limit_sq)));
  assign ent.inlier     = s2_r.inlier;

endmodule

### hw/rtl/rfqg_queue.sv
`timescale 1ns / 1ps

module rfqg_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  rfqg_pkg::entry_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output rfqg_pkg::entry_t pop_data
);

  rfqg_pkg::entry_t            mem [rfqg_pkg::Q_DEPTH];
  logic [rfqg_pkg::Q_PTR_W-1:0] wr_ptr_r;
  logic [rfqg_pkg::Q_PTR_W-1:0] rd_ptr_r;
  logic [rfqg_pkg::Q_PTR_W:0]   count_r;
  logic [rfqg_pkg::Q_PTR_W:0]   count_nxt;
  logic                         do_push;
  logic                         do_pop;

  assign push_ready = count_r != (rfqg_pkg::Q_PTR_W+1)'(rfqg_pkg::Q_DEPTH);
  assign pop_valid  = count_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

### hw/rtl/rfqg_back.sv
`timescale 1ns / 1ps

module rfqg_back #(
  parameter int RECOVERY_COUNT  = 10,
  parameter int MAX_INVALID_RUN = 5,
  parameter int MIN_VALID_RUN   = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ent_valid,
  output logic                ent_ready,
  input  rfqg_pkg::entry_t    ent,
  output logic                out_valid,
  input  logic                out_ready,
  output rfqg_pkg::out_word_t out_word
);

  localparam logic [7:0] RECOVERY_LIM = 8'(RECOVERY_COUNT);
  localparam logic [7:0] INVALID_LIM  = 8'(MAX_INVALID_RUN);
  localparam logic [7:0] VALID_LIM    = 8'(MIN_VALID_RUN);

  logic                in_blackout_r;
  logic                in_blackout_nxt;
  logic [7:0]          blackout_count_r;
  logic [7:0]          blackout_count_nxt;
  logic [7:0]          valid_run_r;
  logic [7:0]          valid_run_nxt;
  logic [7:0]          invalid_run_r;
  logic [7:0]          invalid_run_nxt;
  logic                out_valid_r;
  rfqg_pkg::out_word_t out_word_r;
  rfqg_pkg::out_word_t out_word_nxt;
  logic                pop;

  function automatic logic [7:0] sat_inc(input logic [7:0] c);
    return (c == 8'hff) ? c : c + 8'd1;
  endfunction

  assign pop       = ent_valid && (!out_valid_r || out_ready);
  assign ent_ready = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    in_blackout_nxt    = in_blackout_r;
    blackout_count_nxt = blackout_count_r;
    valid_run_nxt      = valid_run_r;
    invalid_run_nxt    = invalid_run_r;
    out_word_nxt       = '0;
    if (ent.kind == rfqg_pkg::KIND_CHI2) begin
      // chi-square word
      if (!ent.inlier && valid_run_r != 8'd0) begin
        valid_run_nxt = valid_run_r - 8'd1;
      end
      out_word_nxt.inlier = ent.inlier;
    end else begin
      out_word_nxt.quality_ok = ent.quality_ok;
      out_word_nxt.jump_ok    = ent.jump_ok;
      if (in_blackout_r) begin
        blackout_count_nxt = sat_inc(blackout_count_r);
        if (blackout_count_nxt >= RECOVERY_LIM) begin
          in_blackout_nxt    = 1'b0;
          valid_run_nxt      = 8'd0;
          invalid_run_nxt    = 8'd0;
          blackout_count_nxt = 8'd0;
        end
      end else if (ent.jump_ok) begin
        valid_run_nxt         = sat_inc(valid_run_r);
        invalid_run_nxt       = 8'd0;
        out_word_nxt.accepted = valid_run_nxt >= VALID_LIM;
      end else begin
        invalid_run_nxt = sat_inc(invalid_run_r);
        valid_run_nxt   = 8'd0;
        if (invalid_run_nxt >= INVALID_LIM) begin
          in_blackout_nxt    = 1'b1;
          blackout_count_nxt = 8'd0;
        end
      end
    end
    out_word_nxt.blackout = in_blackout_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_blackout_r    <= 1'b0;
      blackout_count_r <= 8'd0;
      valid_run_r      <= 8'd0;
      invalid_run_r    <= 8'd0;
      out_valid_r      <= 1'b0;
    end else begin
      if (pop) begin
        in_blackout_r    <= in_blackout_nxt;
        blackout_count_r <= blackout_count_nxt;
        valid_run_r      <= valid_run_nxt;
        invalid_run_r    <= invalid_run_nxt;
        out_valid_r      <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_word_r <= out_word_nxt;
    end
  end

`ifndef SYNTHESIS
  a_blackout_clears_valid_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_blackout_r |-> valid_run_r == 8'd0)
    else $error("valid run nonzero during blackout");

  a_blackout_count_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    blackout_count_r < RECOVERY_LIM)
    else $error("blackout count reached recovery limit");

  a_invalid_run_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    !in_blackout_r |-> invalid_run_r < INVALID_LIM)
    else $error("invalid run at limit outside blackout");

  a_accept_needs_layers: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.accepted) |-> (out_word_r.quality_ok && out_word_r.jump_ok))
    else $error("accepted word failed an earlier layer");
`endif

endmodule

### hw/rtl/rtk_fix_quality_gate_top.sv
`timescale 1ns / 1ps

// channel   dir  handshake      word
// in_ch     in   valid/ready    rfqg_pkg::in_word_t, fix or chi-square word
// out_ch    out  valid/ready    rfqg_pkg::out_word_t, one result per input word
// cfg_*     in   cfg_we only    cfg_index selects register, cfg_data low bits
//
// one word per cycle while out_ch keeps up; path: front stages, queue, output register
// front: squares in stage one, sums in stage two, limit compare into a four-entry queue
// back: run counters update one word per cycle into the output register unless out_ch stalls
// synchronous active-low reset clears counters, queue and valid bits, restores register defaults
// a stall on out_ch fills the queue, then holds the front pipeline and drops in_ch.ready

module rtk_fix_quality_gate_top #(
  parameter int RECOVERY_COUNT  = 10,
  parameter int MAX_INVALID_RUN = 5,
  parameter int MIN_VALID_RUN   = 3
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  rfqg_in_if.sink                              in_ch,
  rfqg_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [rfqg_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rfqg_pkg::CFG_DATA_W-1:0]      cfg_data
);

  rfqg_pkg::cfg_t   cfg_r;
  logic             fe_valid;
  logic             fe_ready;
  rfqg_pkg::entry_t fe_ent;
  logic             be_valid;
  logic             be_ready;
  rfqg_pkg::entry_t be_ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accept_float_mode <= rfqg_pkg::RST_ACCEPT_FLOAT_MODE;
      cfg_r.min_sat_count     <= rfqg_pkg::RST_MIN_SAT_COUNT;
      cfg_r.max_dilution      <= rfqg_pkg::RST_MAX_DILUTION;
      cfg_r.max_corr_age      <= rfqg_pkg::RST_MAX_CORR_AGE;
      cfg_r.max_odom_gap      <= rfqg_pkg::RST_MAX_ODOM_GAP;
      cfg_r.jump3d_limit_sq   <= rfqg_pkg::RST_JUMP3D_LIMIT_SQ;
      cfg_r.jump2d_limit_sq   <= rfqg_pkg::RST_JUMP2D_LIMIT_SQ;
      cfg_r.chi2_limit        <= rfqg_pkg::RST_CHI2_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rfqg_pkg::CFG_ACCEPT_FLOAT_MODE: cfg_r.accept_float_mode <= cfg_data[0];
        rfqg_pkg::CFG_MIN_SAT_COUNT:     cfg_r.min_sat_count     <= cfg_data[5:0];
        rfqg_pkg::CFG_MAX_DILUTION:      cfg_r.max_dilution      <= cfg_data[13:0];
        rfqg_pkg::CFG_MAX_CORR_AGE:      cfg_r.max_corr_age      <= cfg_data[15:0];
        rfqg_pkg::CFG_MAX_ODOM_GAP:      cfg_r.max_odom_gap      <= cfg_data[14:0];
        rfqg_pkg::CFG_JUMP3D_LIMIT_SQ:   cfg_r.jump3d_limit_sq   <= cfg_data[47:0];
        rfqg_pkg::CFG_JUMP2D_LIMIT_SQ:   cfg_r.jump2d_limit_sq   <= cfg_data[47:0];
        rfqg_pkg::CFG_CHI2_LIMIT:        cfg_r.chi2_limit        <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  rfqg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_word   (in_ch.data),
    .ent_valid (fe_valid),
    .ent_ready (fe_ready),
    .ent       (fe_ent)
  );

  rfqg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fe_valid),
    .push_ready (fe_ready),
    .push_data  (fe_ent),
    .pop_valid  (be_valid),
    .pop_ready  (be_ready),
    .pop_data   (be_ent)
  );

  rfqg_back #(
    .RECOVERY_COUNT  (RECOVERY_COUNT),
    .MAX_INVALID_RUN (MAX_INVALID_RUN),
    .MIN_VALID_RUN   (MIN_VALID_RUN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ent_valid (be_valid),
    .ent_ready (be_ready),
    .ent       (be_ent),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_word  (out_ch.data)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int BLACKOUT_LEN        = 10;
  localparam int REJECTS_TO_BLACKOUT = 5;
  localparam int GOOD_RUN_MIN        = 3;
  localparam int CYCLE_LIMIT         = 1000000;
  localparam int LONG_HOLD           = 300;
  localparam int DRAIN_TAIL          = 8;

  localparam logic [1:0] SOL_NONE    = 2'd0;
  localparam logic [1:0] SOL_UNKNOWN = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [rfqg_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [rfqg_pkg::CFG_DATA_W-1:0]  cfg_data;

  rfqg_in_if  in_ch ();
  rfqg_out_if out_ch ();

  rtk_fix_quality_gate_top #(
    .RECOVERY_COUNT (BLACKOUT_LEN),
    .MAX_INVALID_RUN(REJECTS_TO_BLACKOUT),
    .MIN_VALID_RUN  (GOOD_RUN_MIN)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // gate state and register copy
  rfqg_pkg::cfg_t gate_cfg;
  logic           bo_active;
  logic [7:0]     bo_count;
  logic [7:0]     good_run;
  logic [7:0]     bad_run;
  int             best_run;

  rfqg_pkg::out_word_t pending_verdicts[$];
  rfqg_pkg::out_word_t want_w;

  int  fail_count;
  int  cycle_count;
  int  words_sent;
  int  chi_words;
  int  n_accepted;
  int  n_blackouts;
  int  n_settings;
  int  in_stall_cycles;
  logic prev_blackout;

  bit no_idle;
  bit long_hold_req;
  int rx_hold;

  function automatic logic [7:0] bump(logic [7:0] c);
    return (c == 8'hFF) ? c : c + 8'd1;
  endfunction

  function automatic logic quality_pass(rfqg_pkg::in_word_t w);
    logic type_ok;
    type_ok = (w.sol_mode == rfqg_pkg::SOL_FIXED) ||
              (gate_cfg.accept_float_mode && w.sol_mode == rfqg_pkg::SOL_FLOAT);
    return type_ok && (w.sat_count >= gate_cfg.min_sat_count) &&
           (w.dilution <= gate_cfg.max_dilution) && (w.corr_age <= gate_cfg.max_corr_age);
  endfunction

  function automatic logic offset_pass(rfqg_pkg::in_word_t w);
    logic [16:0] gap_abs;
    longint      e, n, u;
    logic [63:0] sq2, sq3;
    if (!w.odom_valid) return 1'b1;
    gap_abs = w.time_gap[15] ? 17'h10000 - {1'b0, w.time_gap} : {1'b0, w.time_gap};
    if (gap_abs > {2'b00, gate_cfg.max_odom_gap}) return 1'b1;
    e = longint'(signed'(w.east_offset));
    n = longint'(signed'(w.north_offset));
    u = longint'(signed'(w.up_offset));
    sq2 = e * e + n * n;
    sq3 = sq2 + u * u;
    if (sq3 > {16'h0, gate_cfg.jump3d_limit_sq}) return 1'b0;
    if (sq2 > {16'h0, gate_cfg.jump2d_limit_sq}) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic run_update(logic ok);
    if (bo_active) begin
      bo_count = bump(bo_count);
      if (bo_count >= BLACKOUT_LEN) begin
        bo_active = 1'b0;
        bo_count  = '0;
        good_run  = '0;
        bad_run   = '0;
      end
      return 1'b0;
    end
    if (ok) begin
      good_run = bump(good_run);
      bad_run  = '0;
      if (good_run > best_run) best_run = good_run;
      return good_run >= GOOD_RUN_MIN;
    end
    bad_run  = bump(bad_run);
    good_run = '0;
    if (bad_run >= REJECTS_TO_BLACKOUT) begin
      bo_active = 1'b1;
      bo_count  = '0;
    end
    return 1'b0;
  endfunction

  function automatic rfqg_pkg::out_word_t predict_verdict(rfqg_pkg::in_word_t w);
    rfqg_pkg::out_word_t r;
    logic                l1, l2;
    r = '0;
    if (w.kind == rfqg_pkg::KIND_CHI2) begin
      if (w.chi2_value <= gate_cfg.chi2_limit) r.inlier = 1'b1;
      else if (good_run != 0) good_run = good_run - 8'd1;
    end else begin
      l1 = quality_pass(w);
      l2 = l1 && offset_pass(w);
      r.accepted   = run_update(l1 && l2);
      r.quality_ok = l1;
      r.jump_ok    = l2;
    end
    r.blackout = bo_active;
    return r;
  endfunction

  function automatic void store_reg(logic [rfqg_pkg::CFG_INDEX_W-1:0] idx,
                                    logic [rfqg_pkg::CFG_DATA_W-1:0] d);
    case (idx)
      rfqg_pkg::CFG_ACCEPT_FLOAT_MODE: gate_cfg.accept_float_mode = d[0];
      rfqg_pkg::CFG_MIN_SAT_COUNT:     gate_cfg.min_sat_count     = d[5:0];
      rfqg_pkg::CFG_MAX_DILUTION:      gate_cfg.max_dilution      = d[13:0];
      rfqg_pkg::CFG_MAX_CORR_AGE:      gate_cfg.max_corr_age      = d[15:0];
      rfqg_pkg::CFG_MAX_ODOM_GAP:      gate_cfg.max_odom_gap      = d[14:0];
      rfqg_pkg::CFG_JUMP3D_LIMIT_SQ:   gate_cfg.jump3d_limit_sq   = d[47:0];
      rfqg_pkg::CFG_JUMP2D_LIMIT_SQ:   gate_cfg.jump2d_limit_sq   = d[47:0];
      rfqg_pkg::CFG_CHI2_LIMIT:        gate_cfg.chi2_limit        = d[31:0];
      default: ;
    endcase
  endfunction

  // stimulus generators
  function automatic int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(12, 40);
  endfunction

  function automatic rfqg_pkg::in_word_t noise_word();
    rfqg_pkg::in_word_t w;
    w = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    return w;
  endfunction

  function automatic logic signed [23:0] rand_offset(int k);
    int m;
    m = $urandom_range(0, (1 << k) - 1);
    return $urandom_range(0, 1) ? 24'(-m - 1) : 24'(m);
  endfunction

  function automatic rfqg_pkg::in_word_t make_fix(int mode);
    rfqg_pkg::in_word_t w;
    int                 g, k;
    w = noise_word();
    w.kind = rfqg_pkg::KIND_FIX;
    w.sol_mode = (gate_cfg.accept_float_mode && $urandom_range(0, 1)) ?
                 rfqg_pkg::SOL_FLOAT : rfqg_pkg::SOL_FIXED;
    w.sat_count  = 6'($urandom_range(gate_cfg.min_sat_count, 63));
    w.dilution   = 14'($urandom_range(0, gate_cfg.max_dilution));
    w.corr_age   = 16'($urandom_range(0, gate_cfg.max_corr_age));
    w.odom_valid = ($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 9) != 0) begin
      g = $urandom_range(0, gate_cfg.max_odom_gap);
      w.time_gap = 16'($urandom_range(0, 1) ? -g : g);
    end
    k = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 23) : $urandom_range(0, 12);
    w.east_offset  = rand_offset(k);
    w.north_offset = rand_offset(k);
    w.up_offset    = rand_offset(k);
    if (mode == 2 || (mode == 1 && $urandom_range(0, 7) == 0)) begin
      case ($urandom_range(0, 4))
        0: w.sol_mode = $urandom_range(0, 1) ? SOL_NONE : SOL_UNKNOWN;
        1: w.sol_mode = gate_cfg.accept_float_mode ? SOL_NONE : rfqg_pkg::SOL_FLOAT;
        2: if (gate_cfg.min_sat_count != 0) begin
          w.sat_count = 6'($urandom_range(0, gate_cfg.min_sat_count - 1));
        end else begin
          w.sol_mode = SOL_UNKNOWN;
        end
        3: if (gate_cfg.max_dilution != 14'h3FFF) begin
          w.dilution = 14'($urandom_range(gate_cfg.max_dilution + 1, 16383));
        end else begin
          w.sol_mode = SOL_NONE;
        end
        default: if (gate_cfg.max_corr_age != 16'hFFFF) begin
          w.corr_age = 16'($urandom_range(gate_cfg.max_corr_age + 1, 65535));
        end else begin
          w.sol_mode = SOL_NONE;
        end
      endcase
    end
    return w;
  endfunction

  function automatic rfqg_pkg::in_word_t make_chi();
    rfqg_pkg::in_word_t w;
    int                 r;
    w = noise_word();
    w.kind = rfqg_pkg::KIND_CHI2;
    r = $urandom_range(0, 9);
    if (r < 4) w.chi2_value = gate_cfg.chi2_limit + 32'($urandom_range(0, 4)) - 32'd2;
    else if (r < 7) w.chi2_value = $urandom_range(0, gate_cfg.chi2_limit);
    return w;
  endfunction

  function automatic rfqg_pkg::in_word_t rand_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return make_chi();
    if (r < 22) return noise_word();
    return make_fix(1);
  endfunction

  function automatic rfqg_pkg::in_word_t fix_word(logic [1:0] sol, int sats, int dil, int age,
                                                  int e, int n, int u, int gap, logic ov);
    rfqg_pkg::in_word_t w;
    w = '0;
    w.kind          = rfqg_pkg::KIND_FIX;
    w.sol_mode      = sol;
    w.sat_count     = 6'(sats);
    w.dilution      = 14'(dil);
    w.corr_age      = 16'(age);
    w.east_offset   = 24'(e);
    w.north_offset  = 24'(n);
    w.up_offset     = 24'(u);
    w.time_gap      = 16'(gap);
    w.odom_valid    = ov;
    return w;
  endfunction

  function automatic rfqg_pkg::in_word_t chi_word(logic [31:0] v);
    rfqg_pkg::in_word_t w;
    w = '0;
    w.kind       = rfqg_pkg::KIND_CHI2;
    w.chi2_value = v;
    return w;
  endfunction

  // driving
  task automatic send_word(input rfqg_pkg::in_word_t w);
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    pending_verdicts.push_back(predict_verdict(w));
    words_sent++;
    if (w.kind == rfqg_pkg::KIND_CHI2) chi_words++;
  endtask

  task automatic sender_gap(input int n);
    repeat (n) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      in_ch.data  <= noise_word();
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rfqg_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [rfqg_pkg::CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    store_reg(idx, d);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input rfqg_pkg::cfg_t c);
    drain_results();
    write_reg(rfqg_pkg::CFG_ACCEPT_FLOAT_MODE, rfqg_pkg::CFG_DATA_W'(c.accept_float_mode));
    write_reg(rfqg_pkg::CFG_MIN_SAT_COUNT,     rfqg_pkg::CFG_DATA_W'(c.min_sat_count));
    write_reg(rfqg_pkg::CFG_MAX_DILUTION,      rfqg_pkg::CFG_DATA_W'(c.max_dilution));
    write_reg(rfqg_pkg::CFG_MAX_CORR_AGE,      rfqg_pkg::CFG_DATA_W'(c.max_corr_age));
    write_reg(rfqg_pkg::CFG_MAX_ODOM_GAP,      rfqg_pkg::CFG_DATA_W'(c.max_odom_gap));
    write_reg(rfqg_pkg::CFG_JUMP3D_LIMIT_SQ,   rfqg_pkg::CFG_DATA_W'(c.jump3d_limit_sq));
    write_reg(rfqg_pkg::CFG_JUMP2D_LIMIT_SQ,   rfqg_pkg::CFG_DATA_W'(c.jump2d_limit_sq));
    write_reg(rfqg_pkg::CFG_CHI2_LIMIT,        rfqg_pkg::CFG_DATA_W'(c.chi2_limit));
    n_settings++;
  endtask

  function automatic rfqg_pkg::cfg_t random_config();
    rfqg_pkg::cfg_t c;
    int             rad3, rad2;
    rad3 = $urandom_range(300, 6000);
    rad2 = $urandom_range(200, rad3);
    c.accept_float_mode = 1'($urandom_range(0, 1));
    c.min_sat_count     = 6'($urandom_range(0, 12));
    c.max_dilution      = 14'($urandom_range(50, 600));
    c.max_corr_age      = 16'($urandom_range(500, 10000));
    c.max_odom_gap      = 15'($urandom_range(50, 2000));
    c.jump3d_limit_sq   = 48'(rad3 * rad3);
    c.jump2d_limit_sq   = 48'(rad2 * rad2);
    c.chi2_limit        = $urandom_range(32'h0001_0000, 32'h0010_0000);
    return c;
  endfunction

  // tests
  task automatic test_directed_defaults();
    rfqg_pkg::in_word_t list[$];
    list.push_back(chi_word(32'hFFFF_FFFF));
    list.push_back(chi_word(rfqg_pkg::RST_CHI2_LIMIT));
    repeat (3) list.push_back(fix_word(rfqg_pkg::SOL_FIXED, 6, 200, 5000, 0, 0, 0, 0, 1'b1));
    list.push_back(fix_word(rfqg_pkg::SOL_FIXED, 63, 0, 0, -8388608, -8388608, -8388608,
                            -32768, 1'b1));
    list.push_back(fix_word(rfqg_pkg::SOL_FIXED, 10, 100, 100, 8388607, 8388607, 8388607,
                            32767, 1'b1));
    list.push_back(fix_word(rfqg_pkg::SOL_FIXED, 10, 100, 100, 8388607, -8388608, 8388607,
                            500, 1'b0));
    list.push_back(fix_word(rfqg_pkg::SOL_FIXED, 10, 100, 100, 0, 0, 2000, 500, 1'b1));
    list.push_back(fix_word(rfqg_pkg::SOL_FIXED, 10, 100, 100, 1500, 0, 0, -500, 1'b1));
    list.push_back(chi_word(rfqg_pkg::RST_CHI2_LIMIT + 32'd1));
    // rejects in a row into blackout
    list.push_back(fix_word(rfqg_pkg::SOL_FIXED, 10, 100, 100, 1500, 1, 0, 0, 1'b1));
    list.push_back(fix_word(rfqg_pkg::SOL_FIXED, 10, 100, 100, 0, 0, 2001, 0, 1'b1));
    list.push_back(fix_word(rfqg_pkg::SOL_FLOAT, 10, 100, 100, 0, 0, 0, 0, 1'b1));
    list.push_back(fix_word(SOL_UNKNOWN, 10, 100, 100, 0, 0, 0, 0, 1'b1));
    list.push_back(fix_word(SOL_NONE, 10, 100, 100, 0, 0, 0, 0, 1'b1));
    list.push_back(chi_word(32'h0));
    list.push_back(fix_word(rfqg_pkg::SOL_FIXED, 5, 100, 100, 0, 0, 0, 0, 1'b1));
    list.push_back(fix_word(rfqg_pkg::SOL_FIXED, 10, 201, 100, 0, 0, 0, 0, 1'b1));
    list.push_back(fix_word(rfqg_pkg::SOL_FIXED, 10, 100, 5001, 0, 0, 0, 0, 1'b1));
    list.push_back(fix_word(rfqg_pkg::SOL_FIXED, 6, 200, 5000, 0, 0, 0, 0, 1'b1));
    foreach (list[i]) begin
      send_word(list[i]);
      sender_gap(gap_len());
    end
  endtask

  task automatic test_register_extremes();
    rfqg_pkg::cfg_t c;
    c = '0;
    set_config(c);
    repeat (40) begin
      send_word(rand_item());
      sender_gap(gap_len());
    end
    c.accept_float_mode = 1'b1;
    c.min_sat_count     = 6'd63;
    c.max_dilution      = 14'd9999;
    c.max_corr_age      = 16'hFFFF;
    c.max_odom_gap      = 15'h7FFF;
    c.jump3d_limit_sq   = 48'hFFFF_FFFF_FFFF;
    c.jump2d_limit_sq   = 48'hFFFF_FFFF_FFFF;
    c.chi2_limit        = 32'hFFFF_FFFF;
    set_config(c);
    repeat (40) begin
      send_word(rand_item());
      sender_gap(gap_len());
    end
  endtask

  task automatic test_run_saturation();
    rfqg_pkg::cfg_t c;
    c = '0;
    c.accept_float_mode = 1'b1;
    c.max_dilution      = 14'd9999;
    c.max_corr_age      = 16'hFFFF;
    c.max_odom_gap      = 15'h7FFF;
    c.jump3d_limit_sq   = 48'hFFFF_FFFF_FFFF;
    c.jump2d_limit_sq   = 48'hFFFF_FFFF_FFFF;
    set_config(c);
    no_idle = 1'b1;
    repeat (270) send_word(make_fix(0));
    repeat (6) send_word(chi_word($urandom() | 32'd1));
    repeat (10) send_word(make_fix(0));
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    set_config(random_config());
    long_hold_req = 1'b1;
    no_idle = 1'b1;
    repeat (60) send_word(rand_item());
    no_idle = 1'b0;
    // sender waits for every verdict before going on
    drain_results();
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < 5; p++) begin
      set_config(random_config());
      no_idle = (p == 2);
      for (int i = 0; i < 270; i++) begin
        if ($urandom_range(0, 39) == 0) begin
          repeat ($urandom_range(5, 7)) begin
            send_word(make_fix(2));
            sender_gap(gap_len());
          end
        end else begin
          send_word(rand_item());
          sender_gap(gap_len());
        end
      end
    end
    no_idle = 1'b0;
  endtask

  // receiver side
  initial begin
    out_ch.ready = 1'b0;
    rx_hold = 0;
    forever begin
      @(negedge clk);
      if (rx_hold == 0 && long_hold_req) begin
        rx_hold = LONG_HOLD;
        long_hold_req = 1'b0;
      end else if (rx_hold == 0) begin
        rx_hold = gap_len();
      end
      if (rx_hold != 0) begin
        out_ch.ready <= 1'b0;
        rx_hold--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0b actual %0b", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && !in_ch.ready) in_stall_cycles++;
      if (out_ch.valid && out_ch.ready) begin
        if (pending_verdicts.size() == 0) begin
          $error("result word with nothing pending: %p", out_ch.data);
          fail_count++;
        end else begin
          want_w = pending_verdicts.pop_front();
          check_field("accepted", want_w.accepted, out_ch.data.accepted);
          check_field("quality_ok", want_w.quality_ok, out_ch.data.quality_ok);
          check_field("jump_ok", want_w.jump_ok, out_ch.data.jump_ok);
          check_field("blackout", want_w.blackout, out_ch.data.blackout);
          check_field("inlier", want_w.inlier, out_ch.data.inlier);
          if (want_w.accepted) n_accepted++;
          if (want_w.blackout && !prev_blackout) n_blackouts++;
          prev_blackout = want_w.blackout;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding",
               cycle_count, pending_verdicts.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    no_idle       = 1'b0;
    long_hold_req = 1'b0;
    prev_blackout = 1'b0;
    gate_cfg = '{accept_float_mode: rfqg_pkg::RST_ACCEPT_FLOAT_MODE,
                 min_sat_count:     rfqg_pkg::RST_MIN_SAT_COUNT,
                 max_dilution:      rfqg_pkg::RST_MAX_DILUTION,
                 max_corr_age:      rfqg_pkg::RST_MAX_CORR_AGE,
                 max_odom_gap:      rfqg_pkg::RST_MAX_ODOM_GAP,
                 jump3d_limit_sq:   rfqg_pkg::RST_JUMP3D_LIMIT_SQ,
                 jump2d_limit_sq:   rfqg_pkg::RST_JUMP2D_LIMIT_SQ,
                 chi2_limit:        rfqg_pkg::RST_CHI2_LIMIT};
    bo_active = 1'b0;
    bo_count  = '0;
    good_run  = '0;
    bad_run   = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_defaults();
    test_register_extremes();
    test_run_saturation();
    test_backpressure();
    test_random_settings();
    drain_results();

    if (pending_verdicts.size() != 0) begin
      $error("%0d verdicts never arrived", pending_verdicts.size());
      fail_count++;
    end
    $display("covered %0d words (%0d chi-square) over %0d register settings, %0d fixes accepted",
             words_sent, chi_words, n_settings, n_accepted);
    $display("blackout entered %0d times, longest good run %0d, input held off %0d cycles",
             n_blackouts, best_run, in_stall_cycles);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
